// File: rtl/mg_pkg.sv
// Shared constants and types of the maximum-gap block.
`default_nettype none
package mg_pkg;
  localparam int SAMPLE_BITS = 32;
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int PROD_W = SAMPLE_BITS + IDX_W;
  localparam int MIN_SET = 2;

  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic [SAMPLE_BITS-1:0] min_val;
    logic [SAMPLE_BITS-1:0] max_val;
    logic                   ovf;
  } job_t;

  typedef struct packed {
    logic                   used;
    logic [SAMPLE_BITS-1:0] low;
    logic [SAMPLE_BITS-1:0] high;
  } bucket_t;
endpackage
`default_nettype wire

// File: rtl/mg_in_if.sv
// Input channel of the maximum-gap block: one sample per item.
`default_nettype none
interface mg_in_if;
  logic                           valid;
  logic                           ready;
  logic [mg_pkg::SAMPLE_BITS-1:0] sample;
  logic                           last;
  modport source(output valid, output sample, output last, input ready);
  modport sink(input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/mg_out_if.sv
// Result channel of the maximum-gap block: one result per set.
`default_nettype none
interface mg_out_if;
  logic                           valid;
  logic                           ready;
  logic [mg_pkg::SAMPLE_BITS-1:0] max_gap;
  logic [mg_pkg::CNT_W-1:0]       sample_count;
  logic                           overflow;
  modport source(output valid, output max_gap, output sample_count, output overflow,
                 input ready);
  modport sink(input valid, input max_gap, input sample_count, input overflow,
               output ready);
endinterface
`default_nettype wire

// File: rtl/mg_front.sv
// Front part: loads samples into the sample memory and tracks set statistics.
`default_nettype none
module mg_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mg_in_if.sink                               in_ch,
  output logic                                push,
  output mg_pkg::job_t                        push_job,
  input  wire logic                           set_done,
  input  wire logic [mg_pkg::IDX_W-1:0]       rd_addr,
  output logic [mg_pkg::SAMPLE_BITS-1:0]      rd_data_r
);
  logic [mg_pkg::SAMPLE_BITS-1:0] smem [mg_pkg::MAX_SAMPLES];
  logic [mg_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [mg_pkg::SAMPLE_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic                           ovf_r, ovf_nxt, busy_r;
  logic                           acc, room;

  assign in_ch.ready = !busy_r;
  assign acc  = in_ch.valid && !busy_r;
  assign room = count_r < mg_pkg::CNT_W'(mg_pkg::MAX_SAMPLES);

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ovf_nxt   = ovf_r;
    if (room) begin
      count_nxt = count_r + 1'b1;
      if (in_ch.sample < min_r) min_nxt = in_ch.sample;
      if (in_ch.sample > max_r) max_nxt = in_ch.sample;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign push             = acc && in_ch.last;
  assign push_job.count   = count_nxt;
  assign push_job.min_val = min_nxt;
  assign push_job.max_val = max_nxt;
  assign push_job.ovf     = ovf_nxt;

  always_ff @(posedge clk) begin
    if (acc && room) smem[count_r[mg_pkg::IDX_W-1:0]] <= in_ch.sample;
    rd_data_r <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (set_done) busy_r <= 1'b0;
      if (acc) begin
        if (in_ch.last) begin
          count_r <= '0;
          min_r   <= '1;
          max_r   <= '0;
          ovf_r   <= 1'b0;
          busy_r  <= 1'b1;
        end else begin
          count_r <= count_nxt;
          min_r   <= min_nxt;
          max_r   <= max_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/mg_jobq.sv
// Two-entry queue of closed sets between the front and back parts.
`default_nettype none
module mg_jobq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  mg_pkg::job_t      push_job,
  input  wire logic         pop,
  output logic              avail,
  output mg_pkg::job_t      head
);
  mg_pkg::job_t ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   fill_r;

  assign avail = fill_r != 2'd0;
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && fill_r != 2'd2) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push && fill_r != 2'd2) wp_r <= !wp_r;
      if (pop && avail) rp_r <= !rp_r;
      fill_r <= fill_r + 2'((push && fill_r != 2'd2) ? 1 : 0) - 2'((pop && avail) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// File: rtl/mg_back.sv
// Back part: bucket clearing, pipelined bucket placement, gap scan and result register.
`default_nettype none
module mg_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       job_avail,
  input  mg_pkg::job_t                    job,
  output logic                            job_pop,
  output logic [mg_pkg::IDX_W-1:0]        rd_addr,
  input  wire logic [mg_pkg::SAMPLE_BITS-1:0] rd_data_r,
  output logic                            set_done,
  mg_out_if.source                        out_ch
);
  localparam int SB = mg_pkg::SAMPLE_BITS;
  localparam int IW = mg_pkg::IDX_W;
  localparam int PW = mg_pkg::PROD_W;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_CLEAR = 3'd1, ST_PLACE = 3'd2,
                         ST_DRAIN = 3'd3, ST_SCAN = 3'd4, ST_SCAN_END = 3'd5,
                         ST_EMIT = 3'd6;

  logic [2:0]           state_r;
  logic [IW-1:0]        idx_r, nm1_r;
  logic [SB-1:0]        min_r, span_r, best_r, prev_r;
  logic [mg_pkg::CNT_W-1:0] cnt_r;
  logic                 ovf_r, have_prev_r;

  // Bucket memory.
  mg_pkg::bucket_t      bmem [mg_pkg::MAX_SAMPLES];
  mg_pkg::bucket_t      brd_r, wdata, upd_cur;
  logic [IW-1:0]        waddr, raddr;
  logic                 wen;

  // Placement pipeline.
  logic                 s1_v_r;
  logic [SB-1:0]        off;
  logic                 dv_r [IW+1];
  logic [PW-1:0]        drem_r [IW+1];
  logic [IW-1:0]        dq_r [IW+1];
  logic [SB-1:0]        dval_r [IW+1];
  logic                 dge_r [IW+1];
  logic [IW-1:0]        bk;
  logic                 u_v_r, u_hit_r;
  logic [IW-1:0]        u_k_r;
  logic [SB-1:0]        u_val_r;
  mg_pkg::bucket_t      u_fwd_r;
  logic                 inflight;
  logic                 sc_v_r;
  logic [SB-1:0]        gap;

  assign off = rd_data_r - min_r;
  assign bk  = dge_r[IW] ? nm1_r : dq_r[IW];

  always_comb begin
    inflight = s1_v_r || u_v_r;
    for (int s = 0; s <= IW; s++) inflight = inflight || dv_r[s];
  end

  assign rd_addr = idx_r;
  assign raddr   = (state_r == ST_SCAN) ? idx_r : bk;

  always_comb begin
    upd_cur = u_hit_r ? u_fwd_r : brd_r;
    wdata.used = 1'b1;
    if (!upd_cur.used) begin
      wdata.low  = u_val_r;
      wdata.high = u_val_r;
    end else begin
      wdata.low  = (u_val_r < upd_cur.low)  ? u_val_r : upd_cur.low;
      wdata.high = (u_val_r > upd_cur.high) ? u_val_r : upd_cur.high;
    end
    wen   = u_v_r;
    waddr = u_k_r;
    if (state_r == ST_CLEAR) begin
      wen   = 1'b1;
      waddr = idx_r;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) bmem[waddr] <= wdata;
    brd_r <= bmem[raddr];
  end

  // Divider stage s resolves quotient bit IW-1-s by compare and subtract.
  always_ff @(posedge clk) begin
    drem_r[0] <= PW'(off) * PW'(nm1_r);
    dq_r[0]   <= '0;
    dval_r[0] <= rd_data_r;
    dge_r[0]  <= off >= span_r;
    for (int s = 0; s < IW; s++) begin
      if (drem_r[s] >= (PW'(span_r) << (IW - 1 - s))) begin
        drem_r[s+1] <= drem_r[s] - (PW'(span_r) << (IW - 1 - s));
        dq_r[s+1]   <= dq_r[s] | (IW'(1) << (IW - 1 - s));
      end else begin
        drem_r[s+1] <= drem_r[s];
        dq_r[s+1]   <= dq_r[s];
      end
      dval_r[s+1] <= dval_r[s];
      dge_r[s+1]  <= dge_r[s];
    end
    u_k_r   <= bk;
    u_val_r <= dval_r[IW];
    u_hit_r <= u_v_r && (u_k_r == bk);
    u_fwd_r <= wdata;
  end

  assign gap      = brd_r.low - prev_r;
  assign job_pop  = (state_r == ST_IDLE) && job_avail;
  assign set_done = (state_r == ST_EMIT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      s1_v_r       <= 1'b0;
      u_v_r        <= 1'b0;
      sc_v_r       <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int s = 0; s <= IW; s++) dv_r[s] <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ST_PLACE);
      dv_r[0] <= s1_v_r;
      for (int s = 0; s < IW; s++) dv_r[s+1] <= dv_r[s];
      u_v_r  <= dv_r[IW];
      sc_v_r <= (state_r == ST_SCAN);
      if (set_done) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (sc_v_r && brd_r.used) begin
        if (have_prev_r && gap > best_r) best_r <= gap;
        prev_r      <= brd_r.high;
        have_prev_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_avail) begin
            cnt_r       <= job.count;
            ovf_r       <= job.ovf;
            min_r       <= job.min_val;
            span_r      <= job.max_val - job.min_val;
            nm1_r       <= IW'(job.count - 1'b1);
            idx_r       <= '0;
            best_r      <= '0;
            have_prev_r <= 1'b0;
            if (job.count < mg_pkg::CNT_W'(mg_pkg::MIN_SET) || job.max_val <= job.min_val)
              state_r <= ST_EMIT;
            else
              state_r <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == nm1_r) begin
            idx_r   <= '0;
            state_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == nm1_r) begin
            idx_r   <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!inflight) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == nm1_r) state_r <= ST_SCAN_END;
        end
        ST_SCAN_END: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.max_gap      <= best_r;
            out_ch.sample_count <= cnt_r;
            out_ch.overflow     <= ovf_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/bucket_maximum_gap.sv
// Top level of the maximum-gap block: front loader, set queue and bucket engine.
//
// Usage: samples arrive on in_ch, one per item, and the item with last set closes
// the set. The block answers each set with one item on out_ch: the largest gap
// between neighbors in sorted order, the number of samples used and an overflow
// flag. Up to 1024 samples are kept; further samples of a set are dropped and
// flag overflow, and a dropped last sample still closes the set.
// Samples load at one per cycle while in_ch is ready. After the last sample the
// input stays stalled while the set is worked out: the bucket marks are cleared,
// the samples stream into the bucket pipeline (a multiplier and a ten-stage
// divider), and the buckets are scanned. Sets of fewer than two samples, or of
// equal samples, skip these passes and are answered directly.
// The result sits in an output register; a stalled receiver holds it there and
// the next set can be loaded meanwhile, but its result waits for the register.
// Reset (rst_n low, synchronous) empties the queue and output register and
// starts a fresh set; no clearing pass is needed after reset.
`default_nettype none
module bucket_maximum_gap (
  input  wire logic clk,
  input  wire logic rst_n,
  mg_in_if.sink     in_ch,
  mg_out_if.source  out_ch
);
  logic                           push, pop, avail, set_done;
  mg_pkg::job_t                   push_job, head;
  logic [mg_pkg::IDX_W-1:0]       rd_addr;
  logic [mg_pkg::SAMPLE_BITS-1:0] rd_data_r;

  // Front: accepts items, stores samples, closes sets into the queue.
  mg_front u_front (
    .clk, .rst_n, .in_ch, .push, .push_job, .set_done, .rd_addr, .rd_data_r
  );

  // Queue of closed sets.
  mg_jobq u_jobq (
    .clk, .rst_n, .push, .push_job, .pop, .avail, .head
  );

  // Back: places samples into buckets and scans for the largest gap.
  mg_back u_back (
    .clk, .rst_n, .job_avail(avail), .job(head), .job_pop(pop), .rd_addr,
    .rd_data_r, .set_done, .out_ch
  );
endmodule
`default_nettype wire

// File: tb/sv/mg_tb_pkg.sv
// Shared item types for the maximum-gap testbench.
package mg_tb_pkg;
  import mg_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] max_gap;
    logic [CNT_W-1:0]       sample_count;
    logic                   overflow;
  } gap_result_t;
endpackage

// File: tb/sv/bucket_maximum_gap_tb.sv
// Self-checking testbench of the maximum-gap block with an exact gap predictor.
module bucket_maximum_gap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mg_pkg::*;
  import mg_tb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;

  mg_in_if  in_ch();
  mg_out_if out_ch();

  bucket_maximum_gap i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Samples waiting to be sent and results waiting to arrive.
  sample_item_t pending_samples[$];
  gap_result_t  expected_gaps[$];

  // Predictor state: the samples of the set being loaded.
  logic [SAMPLE_BITS-1:0] set_samples[$];
  bit                     set_truncated;

  // Idle rates in percent; changed between phases by the stimulus block.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          all_queued;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The largest neighbor gap in sorted order. Sorting gives the same answer as
  // the bucket method, so it serves as an independent check of the hardware.
  function automatic logic [SAMPLE_BITS-1:0] sorted_gap(logic [SAMPLE_BITS-1:0] vals[$]);
    logic [SAMPLE_BITS-1:0] best;
    best = '0;
    vals.sort();
    for (int i = 1; i < vals.size(); i++) begin
      if (vals[i] - vals[i-1] > best) best = vals[i] - vals[i-1];
    end
    return best;
  endfunction

  // Queues one sample for sending and, on a closing sample, the result it causes.
  task automatic push_sample(logic [SAMPLE_BITS-1:0] value, logic close);
    gap_result_t res;
    pending_samples.push_back('{sample: value, last: close});
    if (set_samples.size() < MAX_SAMPLES) begin
      set_samples.push_back(value);
    end else begin
      set_truncated = 1'b1;
    end
    if (close) begin
      res.max_gap      = sorted_gap(set_samples);
      res.sample_count = CNT_W'(set_samples.size());
      res.overflow     = set_truncated;
      expected_gaps.push_back(res);
      set_samples.delete();
      set_truncated = 1'b0;
    end
  endtask

  // A random sample drawn from one of several value ranges, so that sets with
  // tight clusters, small spans and the full 32-bit range all occur.
  function automatic logic [SAMPLE_BITS-1:0] random_sample(int unsigned style,
                                                           logic [SAMPLE_BITS-1:0] base);
    case (style)
      0:       return $urandom();
      1:       return base + $urandom_range(0, 15);
      2:       return ($urandom_range(0, 1) != 0) ? '1 : $urandom_range(0, 3);
      default: return base + $urandom_range(0, 100000);
    endcase
  endfunction

  task automatic random_set(int unsigned len);
    int unsigned            style;
    logic [SAMPLE_BITS-1:0] base;
    style = $urandom_range(0, 3);
    base  = $urandom();
    for (int unsigned i = 0; i < len; i++) begin
      push_sample(random_sample(style, base), i == len - 1);
    end
  endtask

  // Waits until every queued sample is sent and every result has arrived.
  task automatic drain();
    while (pending_samples.size() != 0 || expected_gaps.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed special cases, then three idling phases of random sets.
  initial begin
    int unsigned sent;
    int unsigned len;
    send_idle_pct  = 32;
    recv_idle_pct  = 85;
    mismatch_count = 0;
    all_queued     = 1'b0;
    set_truncated  = 1'b0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // An empty set is impossible, since every item carries a sample; a single
    // sample gives a gap of zero.
    push_sample(32'h1234_5678, 1'b1);
    // All samples equal.
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    // Both extremes of the sample field: the full-range gap.
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    // A small mixed set with two wide gaps.
    push_sample(32'd7, 1'b0);
    push_sample(32'd3, 1'b0);
    push_sample(32'd100, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'hAAAA_5555, 1'b0);
    push_sample(32'h5555_AAAA, 1'b1);

    // Random sets; the first phase also carries one overlong set with a dropped
    // closing sample, which fills the store to capacity.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 85;
        recv_idle_pct = 32;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 0) begin
        random_set(MAX_SAMPLES + 3);
      end
      while (sent < 250 * (phase + 1)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 40);
        random_set(len);
        sent += len;
      end
      drain();
    end
    all_queued = 1'b1;
  end

  // Sender: keeps valid high until the item is taken, idling at random between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
      in_ch.last   <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) void'(pending_samples.pop_front());
      if (pending_samples.size() > (in_ch.valid ? 0 : 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid  <= 1'b1;
        in_ch.sample <= pending_samples[0].sample;
        in_ch.last   <= pending_samples[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random and checks each accepted result against the
  // oldest expected one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gaps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: gap %0d count %0d overflow %0d",
                     out_ch.max_gap, out_ch.sample_count, out_ch.overflow);
        end else begin
          gap_result_t want;
          want = expected_gaps.pop_front();
          if (out_ch.max_gap !== want.max_gap || out_ch.sample_count !== want.sample_count ||
              out_ch.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected gap %0d count %0d overflow %0d, got %0d %0d %0d",
                       want.max_gap, want.sample_count, want.overflow,
                       out_ch.max_gap, out_ch.sample_count, out_ch.overflow);
          end
        end
      end
    end
  end

  // End of run: a short settling time after the last result, or a timeout.
  initial begin
    cycle_count = 0;
    while (!all_queued && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (!all_queued) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (50) @(posedge clk);
      if (mismatch_count == 0 && expected_gaps.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end
endmodule
